/* hdl/s5rp_pkg.sv */
// Shared types and constants of the SOCKS5 request parser.
`default_nettype none
package s5rp_pkg;

    // Pattern window depth
    localparam int PATTERN_BYTES = 8;
    localparam int WIN_BYTES     = (PATTERN_BYTES < 8) ? PATTERN_BYTES : 8;

    // Front queue geometry
    localparam int FQ_DEPTH = 4;
    localparam int FQ_AW    = $clog2(FQ_DEPTH);

    // Result queue geometry
    localparam int RQ_DEPTH = 2;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);

    // Protocol bytes
    localparam logic [7:0] SOCKS_VER    = 8'h05;
    localparam logic [7:0] METH_NOAUTH  = 8'h00;
    localparam logic [7:0] METH_USERPW  = 8'h02;
    localparam logic [7:0] ATYP_IPV4    = 8'h01;
    localparam logic [7:0] ATYP_DOMAIN  = 8'h03;

    // Register file
    localparam logic       CFG_IDX_PATTERN = 1'b0;
    localparam logic       CFG_IDX_LENGTH  = 1'b1;
    localparam logic [63:0] PATTERN_RESET  = 64'h0065_6275_7475_6f79;
    localparam logic [3:0]  LENGTH_RESET   = 4'd7;

    typedef enum logic [2:0] {
        EV_ACCEPT   = 3'd0,
        EV_REJECT   = 3'd1,
        EV_CONN_IP  = 3'd2,
        EV_CONN_DOM = 3'd3,
        EV_BAD_VER  = 3'd4,
        EV_BAD_ATYP = 3'd5
    } t_event;

    typedef enum logic [9:0] {
        PH_VERSION  = 10'b00_0000_0001,
        PH_NMETHODS = 10'b00_0000_0010,
        PH_METHODS  = 10'b00_0000_0100,
        PH_HEADER   = 10'b00_0000_1000,
        PH_ATYPE    = 10'b00_0001_0000,
        PH_IPV4     = 10'b00_0010_0000,
        PH_DLEN     = 10'b00_0100_0000,
        PH_DOMAIN   = 10'b00_1000_0000,
        PH_PORT     = 10'b01_0000_0000,
        PH_IDLE     = 10'b10_0000_0000
    } t_phase;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       new_conn;
    } t_item;

    typedef struct packed {
        t_event      event_res;
        logic [31:0] ipv4_addr;
        logic [7:0]  domain_len;
        logic [15:0] dest_port;
        logic        blocked;
    } t_res;

    // Classified byte handed from front to back
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       new_conn;
        logic       is_ver;
        logic       is_meth;
        logic       is_zero;
        logic       is_ipv4;
        logic       is_dom;
    } t_cls;

    // Head of the front queue as seen by the back
    typedef struct packed {
        logic valid;
        t_cls cls;
    } t_head;

endpackage
`default_nettype wire

/* hdl/s5rp_front.sv */
// Front end: classifies received bytes and buffers them in a short queue.
`default_nettype none
module s5rp_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire s5rp_pkg::t_item i_item,
    output s5rp_pkg::t_head      o_head,
    input  wire logic            i_take
);

    localparam int CW = s5rp_pkg::FQ_AW + 1;

    s5rp_pkg::t_cls r_q [s5rp_pkg::FQ_DEPTH];
    logic [s5rp_pkg::FQ_AW-1:0] r_wr, n_wr;
    logic [s5rp_pkg::FQ_AW-1:0] r_rd, n_rd;
    logic [CW-1:0]              r_cnt, n_cnt;
    s5rp_pkg::t_cls             w_cls;
    logic                       w_wr_en;
    logic                       w_rd_en;

    // Classify the incoming byte
    always_comb begin
        w_cls.rx_byte  = i_item.rx_byte;
        w_cls.new_conn = i_item.new_conn;
        w_cls.is_ver   = (i_item.rx_byte == s5rp_pkg::SOCKS_VER);
        w_cls.is_meth  = (i_item.rx_byte == s5rp_pkg::METH_NOAUTH) ||
                         (i_item.rx_byte == s5rp_pkg::METH_USERPW);
        w_cls.is_zero  = (i_item.rx_byte == 8'd0);
        w_cls.is_ipv4  = (i_item.rx_byte == s5rp_pkg::ATYP_IPV4);
        w_cls.is_dom   = (i_item.rx_byte == s5rp_pkg::ATYP_DOMAIN);
    end

    assign full    = (r_cnt == CW'(s5rp_pkg::FQ_DEPTH));
    assign w_wr_en = push && !full;
    assign w_rd_en = i_take && (r_cnt != '0);

    assign o_head.valid = (r_cnt != '0);
    assign o_head.cls   = r_q[r_rd];

    // Advance pointers and count
    always_comb begin
        n_wr  = w_wr_en ? r_wr + 1'b1 : r_wr;
        n_rd  = w_rd_en ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (w_wr_en && !w_rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_wr_en && w_rd_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store the classified byte
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_q[r_wr] <= w_cls;
        end
    end

endmodule
`default_nettype wire

/* hdl/s5rp_back.sv */
// Back end: parse state machine, pattern window and configuration registers.
`default_nettype none
module s5rp_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_idx,
    input  wire logic [63:0]     i_cfg_data,
    input  wire s5rp_pkg::t_head i_head,
    input  wire logic            i_room,
    output logic                 o_take,
    output logic                 o_fire,
    output s5rp_pkg::t_res       o_res
);

    logic [63:0]         r_pattern;
    logic [3:0]          r_blen;
    s5rp_pkg::t_phase    r_phase, n_phase, w_cur;
    logic [7:0]          r_left, n_left;
    logic                r_meth_ok, n_meth_ok;
    logic                r_kind, n_kind;
    logic [31:0]         r_addr, n_addr;
    logic [7:0]          r_nlen, n_nlen;
    logic [15:0]         r_port, n_port;
    logic [63:0]         r_win, n_win;
    logic [3:0]          r_fill, n_fill;
    logic                r_hit, n_hit;

    logic [7:0]          w_b;
    logic [7:0]          w_left_dec;
    logic [15:0]         w_port_sh;
    logic [63:0]         w_win_sh;
    logic [3:0]          w_fill_inc;
    logic [3:0]          w_len_eff;
    logic [2:0]          w_len_idx;
    logic [s5rp_pkg::WIN_BYTES-1:0] w_match;
    logic                w_hit_now;

    assign o_take = i_head.valid && i_room;
    assign w_b    = i_head.cls.rx_byte;

    assign w_left_dec = r_left - 8'd1;
    assign w_port_sh  = {r_port[7:0], w_b};
    assign w_win_sh   = {w_b, r_win[63:8]};
    assign w_fill_inc = (r_fill < 4'd8) ? r_fill + 4'd1 : r_fill;

    // Clamp the pattern length to the window depth
    assign w_len_eff = (r_blen > 4'(s5rp_pkg::WIN_BYTES)) ?
                       4'(s5rp_pkg::WIN_BYTES) : r_blen;
    assign w_len_idx = 3'(w_len_eff - 4'd1);

    // Compare the newest k bytes of the window with the first k pattern bytes
    for (genvar g = 0; g < s5rp_pkg::WIN_BYTES; g++) begin : g_match
        assign w_match[g] = (w_win_sh[63 -: 8*(g+1)] == r_pattern[8*(g+1)-1:0]);
    end

    assign w_hit_now = (w_len_eff == 4'd0) ||
                       ((w_fill_inc >= w_len_eff) && w_match[w_len_idx]);

    // Step the parser by one byte
    always_comb begin
        n_phase   = r_phase;
        n_left    = r_left;
        n_meth_ok = r_meth_ok;
        n_kind    = r_kind;
        n_addr    = r_addr;
        n_nlen    = r_nlen;
        n_port    = r_port;
        n_win     = r_win;
        n_fill    = r_fill;
        n_hit     = r_hit;
        o_fire    = 1'b0;
        o_res     = '0;
        w_cur     = i_head.cls.new_conn ? s5rp_pkg::PH_VERSION : r_phase;
        if (o_take) begin
            case (w_cur)
                s5rp_pkg::PH_VERSION: begin
                    if (i_head.cls.is_ver) begin
                        n_phase = s5rp_pkg::PH_NMETHODS;
                    end else begin
                        n_phase         = s5rp_pkg::PH_IDLE;
                        o_fire          = 1'b1;
                        o_res.event_res = s5rp_pkg::EV_BAD_VER;
                    end
                end
                s5rp_pkg::PH_NMETHODS: begin
                    n_meth_ok = 1'b0;
                    n_left    = w_b;
                    if (i_head.cls.is_zero) begin
                        n_phase         = s5rp_pkg::PH_IDLE;
                        o_fire          = 1'b1;
                        o_res.event_res = s5rp_pkg::EV_REJECT;
                    end else begin
                        n_phase = s5rp_pkg::PH_METHODS;
                    end
                end
                s5rp_pkg::PH_METHODS: begin
                    n_meth_ok = r_meth_ok || i_head.cls.is_meth;
                    n_left    = w_left_dec;
                    if (w_left_dec == 8'd0) begin
                        o_fire = 1'b1;
                        if (n_meth_ok) begin
                            n_phase         = s5rp_pkg::PH_HEADER;
                            n_left          = 8'd3;
                            o_res.event_res = s5rp_pkg::EV_ACCEPT;
                        end else begin
                            n_phase         = s5rp_pkg::PH_IDLE;
                            o_res.event_res = s5rp_pkg::EV_REJECT;
                        end
                    end
                end
                s5rp_pkg::PH_HEADER: begin
                    n_left = w_left_dec;
                    if (w_left_dec == 8'd0) begin
                        n_phase = s5rp_pkg::PH_ATYPE;
                    end
                end
                s5rp_pkg::PH_ATYPE: begin
                    n_addr = '0;
                    n_port = '0;
                    if (i_head.cls.is_ipv4) begin
                        n_kind  = 1'b0;
                        n_left  = 8'd4;
                        n_phase = s5rp_pkg::PH_IPV4;
                    end else if (i_head.cls.is_dom) begin
                        n_kind  = 1'b1;
                        n_phase = s5rp_pkg::PH_DLEN;
                    end else begin
                        n_phase         = s5rp_pkg::PH_IDLE;
                        o_fire          = 1'b1;
                        o_res.event_res = s5rp_pkg::EV_BAD_ATYP;
                    end
                end
                s5rp_pkg::PH_IPV4: begin
                    n_addr = {r_addr[23:0], w_b};
                    n_left = w_left_dec;
                    if (w_left_dec == 8'd0) begin
                        n_left  = 8'd2;
                        n_phase = s5rp_pkg::PH_PORT;
                    end
                end
                s5rp_pkg::PH_DLEN: begin
                    n_nlen = w_b;
                    n_left = w_b;
                    n_win  = '0;
                    n_fill = '0;
                    n_hit  = (w_len_eff == 4'd0);
                    if (i_head.cls.is_zero) begin
                        n_left  = 8'd2;
                        n_phase = s5rp_pkg::PH_PORT;
                    end else begin
                        n_phase = s5rp_pkg::PH_DOMAIN;
                    end
                end
                s5rp_pkg::PH_DOMAIN: begin
                    n_win  = w_win_sh;
                    n_fill = w_fill_inc;
                    n_hit  = r_hit || w_hit_now;
                    n_left = w_left_dec;
                    if (w_left_dec == 8'd0) begin
                        n_left  = 8'd2;
                        n_phase = s5rp_pkg::PH_PORT;
                    end
                end
                s5rp_pkg::PH_PORT: begin
                    n_port = w_port_sh;
                    n_left = w_left_dec;
                    if (w_left_dec == 8'd0) begin
                        n_phase         = s5rp_pkg::PH_IDLE;
                        o_fire          = 1'b1;
                        o_res.dest_port = w_port_sh;
                        if (!r_kind) begin
                            o_res.event_res = s5rp_pkg::EV_CONN_IP;
                            o_res.ipv4_addr = r_addr;
                        end else begin
                            o_res.event_res  = s5rp_pkg::EV_CONN_DOM;
                            o_res.domain_len = r_nlen;
                            o_res.blocked    = r_hit;
                        end
                    end
                end
                default: begin
                    n_phase = s5rp_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Hold parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= s5rp_pkg::PH_VERSION;
            r_left    <= '0;
            r_meth_ok <= 1'b0;
            r_kind    <= 1'b0;
            r_addr    <= '0;
            r_nlen    <= '0;
            r_port    <= '0;
            r_win     <= '0;
            r_fill    <= '0;
            r_hit     <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_left    <= n_left;
            r_meth_ok <= n_meth_ok;
            r_kind    <= n_kind;
            r_addr    <= n_addr;
            r_nlen    <= n_nlen;
            r_port    <= n_port;
            r_win     <= n_win;
            r_fill    <= n_fill;
            r_hit     <= n_hit;
        end
    end

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= s5rp_pkg::PATTERN_RESET;
            r_blen    <= s5rp_pkg::LENGTH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                s5rp_pkg::CFG_IDX_PATTERN: r_pattern <= i_cfg_data;
                s5rp_pkg::CFG_IDX_LENGTH:  r_blen    <= i_cfg_data[3:0];
                default: begin
                    r_blen <= r_blen;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* hdl/s5rp_resq.sv */
// Result queue: holds parser events until the consumer takes them.
`default_nettype none
module s5rp_resq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr,
    input  wire s5rp_pkg::t_res i_res,
    output logic                o_room,
    output logic                empty,
    input  wire logic           pop,
    output s5rp_pkg::t_res      o_res
);

    localparam int CW = s5rp_pkg::RQ_AW + 1;

    s5rp_pkg::t_res             r_q [s5rp_pkg::RQ_DEPTH];
    logic [s5rp_pkg::RQ_AW-1:0] r_wr;
    logic [s5rp_pkg::RQ_AW-1:0] r_rd;
    logic [CW-1:0]              r_cnt, n_cnt;
    logic                       w_rd_en;

    assign empty   = (r_cnt == '0);
    assign w_rd_en = pop && !empty;
    // A pop in this cycle frees a slot for a new event
    assign o_room  = (r_cnt != CW'(s5rp_pkg::RQ_DEPTH)) || w_rd_en;
    assign o_res   = r_q[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_wr && !w_rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_wr && w_rd_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_rd_en) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    // Store the event
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_q[r_wr] <= i_res;
        end
    end

endmodule
`default_nettype wire

/* hdl/socks5_request_parser_core.sv */
// An accepted byte waits in the byte queue, is parsed, and its event is registered in the event queue.
// Throughput: one byte per cycle while the event queue has room, set by the single-step parse state machine.
// A four-entry byte queue and a two-entry event queue let either side stall alone.
// Reset (synchronous, active low) empties both queues, restarts parsing at the
// version byte and loads the default blocked pattern and length.
`default_nettype none
module socks5_request_parser_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire s5rp_pkg::t_item i_item,
    output logic                 empty,
    input  wire logic            pop,
    output s5rp_pkg::t_res       o_res,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_idx,
    input  wire logic [63:0]     i_cfg_data
);

    s5rp_pkg::t_head w_head;
    s5rp_pkg::t_res  w_res;
    logic            w_take;
    logic            w_fire;
    logic            w_room;

    // Accept and classify bytes
    s5rp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .o_head  (w_head),
        .i_take  (w_take)
    );

    // Parse and match
    s5rp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_head     (w_head),
        .i_room     (w_room),
        .o_take     (w_take),
        .o_fire     (w_fire),
        .o_res      (w_res)
    );

    // Buffer events for the consumer
    s5rp_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_fire),
        .i_res   (w_res),
        .o_room  (w_room),
        .empty   (empty),
        .pop     (pop),
        .o_res   (o_res)
    );

endmodule
`default_nettype wire
